@@ hdl/cldf_pkg.sv @@
package cldf_pkg;

    // line parser modes
    localparam logic [2:0] MODE_PREFIX = 3'd0;
    localparam logic [2:0] MODE_SKIP   = 3'd1;
    localparam logic [2:0] MODE_DIGITS = 3'd2;
    localparam logic [2:0] MODE_BAD    = 3'd3;
    localparam logic [2:0] MODE_OTHER  = 3'd4;

    // error codes carried with a result
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_LENGTH = 3'd1;
    localparam logic [2:0] ERR_BLANK     = 3'd2;
    localparam logic [2:0] ERR_BAD_VALUE = 3'd3;
    localparam logic [2:0] ERR_EARLY_END = 3'd4;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    localparam int        PREFIX_LEN  = 15;
    localparam logic [3:0] PREFIX_LAST = 4'(PREFIX_LEN - 1);

    typedef struct packed {
        logic [2:0] error_code;
        logic       message_done;
        logic       byte_present;
        logic [7:0] payload_byte;
    } cldf_result_t;

    // lowercase header prefix "content-length:"
    function automatic logic [7:0] prefix_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h63; // c
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h6C; // l
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            4'd14:   ch = 8'h3A; // :
            default: ch = 8'hFF;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

@@ hdl/content_length_deframer_top.sv @@
// Channel | Ports                      | Contents (lowest bit first)
// --------+----------------------------+-------------------------------------------
// input   | s_tvalid s_tready s_tdata  | tdata: data_byte[7:0]
//         | s_tuser                    | tuser: stream_ended
// result  | m_tvalid m_tready m_tdata  | tdata: payload_byte[7:0]
//         | m_tuser m_tlast            | tuser: byte_present, error_code[2:0]
//         |                            | tlast: message_done
//
// One request is taken per cycle while s_tready is high; its result, if any, is registered at
// the accepting edge, into the output register or, when that is still occupied, the skid entry.
// The parse state update (prefix compare, acc*10+digit add) is a single pass per byte.
// Reset (aresetn low, synchronous) returns to the header phase with empty buffers.
// A two-entry output stage (register plus skid) keeps s_tready high while one result
// waits; s_tready drops only when both entries are full.
module content_length_deframer_top
    import cldf_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte[7:0]
    input  logic       s_tuser,   // stream_ended
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // payload_byte[7:0]
    output logic [3:0] m_tuser,   // byte_present, error_code[2:0]
    output logic       m_tlast    // message_done
);

    logic         accept;
    logic         res_valid;
    cldf_result_t res;
    logic         space;
    cldf_result_t out_data;

    // take a request whenever the output buffer can absorb its result
    assign s_tready = space;
    assign accept   = s_tvalid && space;

    cldf_parse #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (accept),
        .data_byte    (s_tdata),
        .stream_ended (s_tuser),
        .res_valid    (res_valid),
        .res          (res)
    );

    // hold results until the downstream side takes them
    cldf_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = out_data.payload_byte;
    assign m_tuser = {out_data.error_code, out_data.byte_present};
    assign m_tlast = out_data.message_done;

endmodule

@@ hdl/cldf_parse.sv @@
module cldf_parse
    import cldf_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_accept,
    input  logic [7:0]   data_byte,
    input  logic         stream_ended,
    output logic         res_valid,
    output cldf_result_t res
);

    localparam int WIDE_BITS = LENGTH_BITS + 4;

    logic                   in_payload_reg, in_payload_next;
    logic [2:0]             mode_reg, mode_next;
    logic [3:0]             pos_reg, pos_next;
    logic                   pcr_reg, pcr_next;
    logic                   has_bytes_reg, has_bytes_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic                   known_reg, known_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;

    logic [2:0]             mode_cr;
    logic                   hb_cr;
    logic                   is_digit;
    logic [WIDE_BITS-1:0]   acc_wide;
    logic [WIDE_BITS-1:0]   acc_sum;
    logic [2:0]             line_err;
    logic                   known_after;
    logic [LENGTH_BITS-1:0] len_after;
    logic                   clear_all;
    logic                   clear_line;

    assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    assign acc_wide = WIDE_BITS'(acc_reg);
    assign acc_sum  = (acc_wide << 3) + (acc_wide << 1) + WIDE_BITS'(data_byte[3:0]);

    // a held CR that turned out not to end the line counts as a line byte
    always_comb begin
        mode_cr = mode_reg;
        hb_cr   = has_bytes_reg | pcr_reg;
        if (pcr_reg) begin
            case (mode_reg)
                MODE_PREFIX: mode_cr = MODE_OTHER;
                MODE_SKIP:   mode_cr = MODE_BAD;
                MODE_DIGITS: mode_cr = MODE_BAD;
                default:     mode_cr = mode_reg;
            endcase
        end
    end

    // outcome of ending the current line
    always_comb begin
        line_err    = ERR_NONE;
        known_after = known_reg;
        len_after   = len_reg;
        if (has_bytes_reg) begin
            case (mode_reg)
                MODE_SKIP:   line_err = ERR_BLANK;
                MODE_BAD:    line_err = ERR_BAD_VALUE;
                MODE_DIGITS: begin
                    known_after = 1'b1;
                    len_after   = acc_reg;
                end
                default:     line_err = ERR_NONE;
            endcase
        end
    end

    always_comb begin
        in_payload_next = in_payload_reg;
        mode_next       = mode_reg;
        pos_next        = pos_reg;
        pcr_next        = pcr_reg;
        has_bytes_next  = has_bytes_reg;
        acc_next        = acc_reg;
        known_next      = known_reg;
        len_next        = len_reg;
        res_valid       = 1'b0;
        res             = '0;
        clear_all       = 1'b0;
        clear_line      = 1'b0;

        if (in_payload_reg) begin
            res_valid = 1'b1;
            if (stream_ended) begin
                res.error_code = ERR_EARLY_END;
                clear_all      = 1'b1;
            end else begin
                res.payload_byte = data_byte;
                res.byte_present = 1'b1;
                if (len_reg == LENGTH_BITS'(1)) begin
                    res.message_done = 1'b1;
                    clear_all        = 1'b1;
                end else begin
                    len_next = len_reg - LENGTH_BITS'(1);
                end
            end
        end else if (stream_ended) begin
            res_valid = 1'b1;
            clear_all = 1'b1;
            if (line_err != ERR_NONE) begin
                res.error_code = line_err;
            end else if (!known_after) begin
                res.error_code = ERR_NO_LENGTH;
            end else if (len_after == '0) begin
                res.message_done = 1'b1;
            end else begin
                res.error_code = ERR_EARLY_END;
            end
        end else if (data_byte == CHAR_LF) begin
            clear_line = 1'b1;
            if (has_bytes_reg) begin
                if (line_err != ERR_NONE) begin
                    res_valid      = 1'b1;
                    res.error_code = line_err;
                    clear_all      = 1'b1;
                end else begin
                    known_next = known_after;
                    len_next   = len_after;
                end
            end else if (!known_reg) begin
                res_valid      = 1'b1;
                res.error_code = ERR_NO_LENGTH;
                clear_all      = 1'b1;
            end else if (len_reg == '0) begin
                res_valid        = 1'b1;
                res.message_done = 1'b1;
                clear_all        = 1'b1;
            end else begin
                // empty line: enter payload, count down from the length
                in_payload_next = 1'b1;
                known_next      = 1'b0;
            end
        end else if (data_byte == CHAR_CR) begin
            pcr_next       = 1'b1;
            mode_next      = mode_cr;
            has_bytes_next = hb_cr;
        end else begin
            pcr_next       = 1'b0;
            has_bytes_next = 1'b1;
            mode_next      = mode_cr;
            case (mode_cr)
                MODE_PREFIX: begin
                    if (to_lower(data_byte) == prefix_char(pos_reg)) begin
                        pos_next = pos_reg + 4'd1;
                        if (pos_reg == PREFIX_LAST) begin
                            mode_next = MODE_SKIP;
                        end
                    end else begin
                        mode_next = MODE_OTHER;
                    end
                end
                MODE_SKIP, MODE_DIGITS: begin
                    if (mode_cr == MODE_SKIP &&
                        (data_byte == CHAR_SPACE || data_byte == CHAR_TAB)) begin
                        mode_next = MODE_SKIP;
                    end else if (!is_digit) begin
                        mode_next = MODE_BAD;
                    end else if (acc_sum[WIDE_BITS-1:LENGTH_BITS] != 4'd0) begin
                        mode_next = MODE_BAD;
                    end else begin
                        mode_next = MODE_DIGITS;
                        acc_next  = acc_sum[LENGTH_BITS-1:0];
                    end
                end
                default: mode_next = mode_cr;
            endcase
        end

        if (clear_line || clear_all) begin
            mode_next      = MODE_PREFIX;
            pos_next       = 4'd0;
            pcr_next       = 1'b0;
            has_bytes_next = 1'b0;
            acc_next       = '0;
        end
        if (clear_all) begin
            in_payload_next = 1'b0;
            known_next      = 1'b0;
            len_next        = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg <= 1'b0;
            mode_reg       <= MODE_PREFIX;
            pos_reg        <= 4'd0;
            pcr_reg        <= 1'b0;
            has_bytes_reg  <= 1'b0;
            acc_reg        <= '0;
            known_reg      <= 1'b0;
            len_reg        <= '0;
        end else if (in_accept) begin
            in_payload_reg <= in_payload_next;
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            pcr_reg        <= pcr_next;
            has_bytes_reg  <= has_bytes_next;
            acc_reg        <= acc_next;
            known_reg      <= known_next;
            len_reg        <= len_next;
        end
    end

    // payload phase always has bytes still to pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> (len_reg != '0))
        else $error("payload phase with zero count");

    // a successful or data result never carries an error
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res.byte_present || res.message_done)) |->
            (res.error_code == ERR_NONE))
        else $error("data result with error code");

    // any closing result returns the parser to the header phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && res_valid && (res.error_code != ERR_NONE || res.message_done)) |=>
            (!in_payload_reg && !known_reg && mode_reg == MODE_PREFIX))
        else $error("state not cleared after message end");

endmodule

@@ hdl/cldf_out_buf.sv @@
module cldf_out_buf
    import cldf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  cldf_result_t push_data,
    output logic         space,
    output logic         out_valid,
    input  logic         out_ready,
    output cldf_result_t out_data
);

    logic         out_valid_reg;
    cldf_result_t out_data_reg;
    logic         skid_valid_reg;
    cldf_result_t skid_data_reg;
    logic         pop;

    assign pop       = out_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // advance skid into the output stage once it drains
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_reg <= push_data;
            end else begin
                skid_data_reg <= push_data;
            end
        end
    end

    // skid only fills behind an occupied output stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid full with empty output stage");

    // a push is never offered while the skid is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !skid_valid_reg)
        else $error("push into full buffer");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import cldf_pkg::*;

    localparam int          LENGTH_W        = 32;
    localparam logic [63:0] VALUE_CEIL      = (64'd1 << LENGTH_W) - 64'd1;
    localparam int          RANDOM_REQUESTS = 800;
    localparam int          CALM_TAIL       = 150;   // last requests run with no idling
    localparam int          SETTLE_CYCLES   = 8;     // time for the output register and skid entry to empty
    localparam int          CYCLE_LIMIT     = 400000;
    localparam logic [7:0]  DIGIT_0         = 8'h30;
    localparam logic [7:0]  DIGIT_9         = 8'h39;
    localparam logic [7:0]  LOWER_A         = 8'h61;
    localparam logic [7:0]  LOWER_Z         = 8'h7A;
    localparam logic [7:0]  UPPER_A         = 8'h41;
    localparam logic [7:0]  UPPER_Z         = 8'h5A;
    localparam logic [7:0]  CHAR_COLON      = 8'h3A;

    // Track the framing state of the stream and hold the results it owes.
    class message_ledger;
        string        hdr_text;
        bit           in_payload;
        logic [2:0]   line_mode;
        int unsigned  prefix_pos;
        bit           cr_held;
        bit           line_used;
        logic [63:0]  digit_acc;
        bit           length_known;
        logic [63:0]  message_len;
        logic [63:0]  bytes_left;
        cldf_result_t owed_q[$];
        int           faults;
        int           results_seen;
        int           messages_done;
        int           payload_bytes;
        int           error_tally[8];

        function new();
            hdr_text = "content-length:";
            clear_message();
        endfunction

        function void clear_line();
            line_mode  = MODE_PREFIX;
            prefix_pos = 0;
            cr_held    = 1'b0;
            line_used  = 1'b0;
            digit_acc  = '0;
        endfunction

        function void clear_message();
            clear_line();
            in_payload   = 1'b0;
            length_known = 1'b0;
            message_len  = '0;
            bytes_left   = '0;
        endfunction

        function void owe(logic [7:0] b, bit present, bit done, logic [2:0] code);
            cldf_result_t r;
            r.payload_byte = b;
            r.byte_present = present;
            r.message_done = done;
            r.error_code   = code;
            owed_q.push_back(r);
        endfunction

        // Owe the result that ends a message, then start over on headers.
        function void close_message(logic [7:0] b, bit present, bit done, logic [2:0] code);
            owe(b, present, done, code);
            clear_message();
        endfunction

        function logic [7:0] fold_case(logic [7:0] c);
            return (c >= UPPER_A && c <= UPPER_Z) ? (c | 8'h20) : c;
        endfunction

        function void absorb_char(logic [7:0] c);
            logic [63:0] d;
            line_used = 1'b1;
            if (line_mode == MODE_PREFIX) begin
                if (prefix_pos < PREFIX_LEN && fold_case(c) == 8'(hdr_text[prefix_pos])) begin
                    prefix_pos++;
                    if (prefix_pos == PREFIX_LEN) begin
                        line_mode = MODE_SKIP;
                    end
                end else begin
                    line_mode = MODE_OTHER;
                end
                return;
            end
            if (line_mode == MODE_SKIP) begin
                if (c == CHAR_SPACE || c == CHAR_TAB) begin
                    return;
                end
                line_mode = MODE_DIGITS;
            end
            if (line_mode == MODE_DIGITS) begin
                if (c >= DIGIT_0 && c <= DIGIT_9) begin
                    d = 64'(c - DIGIT_0);
                    if (digit_acc > (VALUE_CEIL - d) / 64'd10) begin
                        line_mode = MODE_BAD;
                    end else begin
                        digit_acc = digit_acc * 64'd10 + d;
                    end
                end else begin
                    line_mode = MODE_BAD;
                end
            end
        endfunction

        // Finish a line: -1 for an empty line, 0 for nothing, else an error code.
        function int close_line();
            int r;
            r = 0;
            if (!line_used) begin
                r = -1;
            end else if (line_mode == MODE_SKIP) begin
                r = ERR_BLANK;
            end else if (line_mode == MODE_BAD) begin
                r = ERR_BAD_VALUE;
            end else if (line_mode == MODE_DIGITS) begin
                length_known = 1'b1;
                message_len  = digit_acc;
            end
            clear_line();
            return r;
        endfunction

        function void headers_done(bit ended);
            if (!length_known) begin
                close_message(8'h00, 0, 0, ERR_NO_LENGTH);
            end else if (message_len == 0) begin
                close_message(8'h00, 0, 1, ERR_NONE);
            end else if (ended) begin
                close_message(8'h00, 0, 0, ERR_EARLY_END);
            end else begin
                in_payload   = 1'b1;
                bytes_left   = message_len;
                length_known = 1'b0;
            end
        endfunction

        function void take_request(logic [7:0] c, logic ended);
            int r;
            if (in_payload) begin
                if (ended) begin
                    close_message(8'h00, 0, 0, ERR_EARLY_END);
                    return;
                end
                bytes_left--;
                if (bytes_left == 0) begin
                    close_message(c, 1, 1, ERR_NONE);
                end else begin
                    owe(c, 1, 0, ERR_NONE);
                end
                return;
            end
            if (ended) begin
                if (line_used || cr_held) begin
                    r = close_line();
                    if (r > 0) begin
                        close_message(8'h00, 0, 0, 3'(r));
                        return;
                    end
                end
                headers_done(1'b1);
                return;
            end
            if (c == CHAR_LF) begin
                r = close_line();
                if (r > 0) begin
                    close_message(8'h00, 0, 0, 3'(r));
                end else if (r < 0) begin
                    headers_done(1'b0);
                end
                return;
            end
            // a held CR that is not followed by LF is an ordinary line byte
            if (cr_held) begin
                cr_held = 1'b0;
                absorb_char(CHAR_CR);
            end
            if (c == CHAR_CR) begin
                cr_held = 1'b1;
            end else begin
                absorb_char(c);
            end
        endfunction

        function void note_fault(string what, cldf_result_t got, cldf_result_t want);
            faults++;
            if (faults <= 10) begin
                $display("%0t: %s: got byte=%02h present=%0b done=%0b err=%0d, want byte=%02h present=%0b done=%0b err=%0d",
                         $time, what, got.payload_byte, got.byte_present, got.message_done,
                         got.error_code, want.payload_byte, want.byte_present,
                         want.message_done, want.error_code);
            end
        endfunction

        function void match_result(logic [7:0] data, logic [3:0] user, logic last);
            cldf_result_t got;
            cldf_result_t want;
            got.payload_byte = data;
            got.byte_present = user[0];
            got.error_code   = user[3:1];
            got.message_done = last;
            results_seen++;
            if (owed_q.size() == 0) begin
                note_fault("result with nothing owed", got, '0);
                return;
            end
            want = owed_q.pop_front();
            if (got.payload_byte !== want.payload_byte || got.byte_present !== want.byte_present
                || got.message_done !== want.message_done
                || got.error_code !== want.error_code) begin
                note_fault("result mismatch", got, want);
            end
            if (want.message_done) begin
                messages_done++;
            end
            if (want.byte_present) begin
                payload_bytes++;
            end
            error_tally[want.error_code]++;
        endfunction
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // data_byte[7:0]
    logic       s_tuser  = 1'b0;    // stream_ended
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // payload_byte[7:0]
    logic [3:0] m_tuser;            // byte_present, error_code[2:0]
    logic       m_tlast;            // message_done

    message_ledger ledger = new();
    bit            idle_on = 1'b1;
    int unsigned   stall_left = 0;
    int            cycle_count = 0;
    int            requests_sent = 0;
    int            directed_sent = 0;
    string         ceil_txt;

    content_length_deframer_top #(
        .LENGTH_BITS(LENGTH_W)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Give up once the cycle counter hits the limit.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: check every accepted result, stall in random bursts while idling is on.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            ledger.match_result(m_tdata, m_tuser, m_tlast);
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(0, 15);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offer one request, maybe after a gap, and hold it until it is taken.
    task automatic send_request(input logic [7:0] b, input logic ended);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= ended;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ledger.take_request(b, ended);
        requests_sent++;
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic drain_wait();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (ledger.owed_q.size() != 0) @(posedge aclk);
    endtask

    task automatic put_byte(input logic [7:0] b);
        send_request(b, 1'b0);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_byte(s[i]);
        end
    endtask

    task automatic put_eol(input bit with_cr);
        if (with_cr) begin
            put_byte(CHAR_CR);
        end
        put_byte(CHAR_LF);
    endtask

    task automatic rand_eol();
        put_eol($urandom_range(0, 1));
    endtask

    // End of stream; the data byte rides along and must be ignored.
    task automatic put_end();
        send_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic put_blanks(input int n);
        repeat (n) put_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
    endtask

    task automatic put_prefix();
        string      p;
        logic [7:0] c;
        p = "content-length:";
        for (int i = 0; i < p.len(); i++) begin
            c = p[i];
            if (c >= LOWER_A && c <= LOWER_Z && $urandom_range(0, 1)) begin
                c = c - 8'd32;
            end
            put_byte(c);
        end
    endtask

    task automatic put_length_line(input string digits, input bit terminate);
        put_prefix();
        put_blanks($urandom_range(0, 2));
        put_text(digits);
        if (terminate) begin
            rand_eol();
        end
    endtask

    task automatic put_payload(input int n);
        repeat (n) put_byte(8'($urandom_range(0, 255)));
    endtask

    // A header line that is not a length header, sometimes with a bare CR inside.
    task automatic put_other_line(input bit terminate);
        int n;
        case ($urandom_range(0, 3))
            0: put_text("Content-Type: text/plain");
            1: put_text("Content-Lengt: 9");
            2: put_text("Content-Length 9");
            default: begin
                n = $urandom_range(1, 10);
                repeat (n) begin
                    if ($urandom_range(0, 7) == 0) begin
                        put_byte(CHAR_CR);
                    end
                    put_byte(8'($urandom_range(8'h21, 8'h7E)));
                end
            end
        endcase
        if (terminate) begin
            rand_eol();
        end
    endtask

    task automatic put_noise();
        int         n;
        logic [7:0] b;
        n = $urandom_range(1, 12);
        repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: b = CHAR_LF;
                    1: b = CHAR_CR;
                    2: b = CHAR_SPACE;
                    default: b = CHAR_COLON;
                endcase
            end
            put_byte(b);
        end
        // resync: finish any partial line, then close the header block
        put_eol(0);
        put_eol(0);
    endtask

    // One random message: mostly well-formed framing, the rest broken or noise.
    task automatic random_message();
        int    k;
        int    len;
        string digits;
        k   = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 6);
        if (k < 65) begin
            repeat ($urandom_range(0, 2)) put_other_line(1);
            if ($urandom_range(0, 4) == 0) begin
                // earlier header that the next one overrides
                if ($urandom_range(0, 2) == 0) begin
                    put_length_line(ceil_txt, 1);
                end else begin
                    put_length_line($sformatf("%0d", $urandom_range(0, 999)), 1);
                end
            end
            digits = $sformatf("%0d", len);
            if ($urandom_range(0, 9) == 0) begin
                digits = {"00", digits};
            end
            put_length_line(digits, 1);
            if ($urandom_range(0, 3) == 0) begin
                put_other_line(1);
            end
            rand_eol();
            put_payload(len);
        end else if (k < 70) begin
            put_prefix();
            put_blanks($urandom_range(0, 3));
            rand_eol();
        end else if (k < 77) begin
            put_prefix();
            put_blanks($urandom_range(0, 2));
            if ($urandom_range(0, 1)) begin
                put_text($sformatf("%0d", $urandom_range(0, 99)));
            end
            case ($urandom_range(0, 4))
                0: put_blanks(1);
                1: put_byte($urandom_range(0, 1) ? 8'h2D : 8'h2B);
                2: put_byte(8'($urandom_range(LOWER_A, LOWER_Z)));
                3: begin
                    put_byte(CHAR_CR);
                    put_byte(8'($urandom_range(DIGIT_0, DIGIT_9)));
                end
                default: put_byte(8'h2F);
            endcase
            if ($urandom_range(0, 1)) begin
                put_text($sformatf("%0d", $urandom_range(0, 9)));
            end
            rand_eol();
        end else if (k < 81) begin
            if ($urandom_range(0, 1)) begin
                put_length_line($sformatf("%0d", VALUE_CEIL + 64'd1 + $urandom_range(0, 1000)), 1);
            end else begin
                put_length_line($sformatf("%0d%0d", VALUE_CEIL, $urandom_range(0, 9)), 1);
            end
        end else if (k < 85) begin
            repeat ($urandom_range(0, 2)) put_other_line(1);
            rand_eol();
        end else if (k < 89) begin
            len = $urandom_range(1, 8);
            put_length_line($sformatf("%0d", len), 1);
            rand_eol();
            put_payload($urandom_range(0, len - 1));
            put_end();
        end else if (k < 93) begin
            if ($urandom_range(0, 1)) begin
                put_other_line(1);
            end
            case ($urandom_range(0, 3))
                0: put_other_line(0);
                1: put_length_line($sformatf("%0d", $urandom_range(0, 3)), 0);
                2: put_length_line($sformatf("%0d", $urandom_range(0, 3)), 1);
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0) begin
                put_byte(CHAR_CR);
            end
            put_end();
        end else begin
            put_noise();
        end
    endtask

    initial begin
        bit paused;
        int random_sent;
        paused   = 1'b0;
        ceil_txt = $sformatf("%0d", VALUE_CEIL);

        // hold reset, then release it for good
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // zero length with CRLF line ends
        put_text("Content-Length: 0");
        put_eol(1);
        put_eol(1);
        // mixed case, tab before the value, extreme payload bytes
        put_text("CONTENT-length:");
        put_byte(CHAR_TAB);
        put_text(" 3");
        put_eol(0);
        put_eol(0);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h80);
        // blank value
        put_text("content-length: ");
        put_eol(1);
        // bad values: letter, sign, trailing blank, CR inside the value
        put_text("Content-Length: 1x");
        put_eol(0);
        put_text("Content-Length: -1");
        put_eol(0);
        put_text("Content-Length:5 ");
        put_eol(1);
        put_text("Content-Length: 2");
        put_byte(CHAR_CR);
        put_text("3");
        put_eol(0);
        // one past the largest value
        put_text({"Content-Length: ", $sformatf("%0d", VALUE_CEIL + 64'd1)});
        put_eol(0);
        // largest value accepted, then overridden by a later header
        put_text({"Content-Length: ", ceil_txt});
        put_eol(0);
        put_text("Content-Length: 1");
        put_eol(1);
        put_eol(1);
        put_byte(CHAR_LF);
        // bare CR inside an ordinary line, then no length header
        put_text("X-Note: a");
        put_byte(CHAR_CR);
        put_text("b");
        put_eol(0);
        put_eol(0);
        // stream ends inside the payload
        put_text("Content-Length: 2");
        put_eol(0);
        put_eol(0);
        put_byte(8'h41);
        put_end();
        // stream ends on a partial zero-length line
        put_text("Content-Length: 0");
        put_end();
        // stream ends after a nonzero header, with a held CR
        put_text("Content-Length: 4");
        put_byte(CHAR_CR);
        put_end();
        // lone end, and a held CR then end
        put_end();
        put_byte(CHAR_CR);
        put_end();
        directed_sent = requests_sent;

        // hold the sender until everything owed has come back
        drain_wait();

        random_sent = 0;
        while (random_sent < RANDOM_REQUESTS) begin
            idle_on = (random_sent < RANDOM_REQUESTS - CALM_TAIL);
            if (!paused && random_sent >= RANDOM_REQUESTS / 2) begin
                paused = 1'b1;
                drain_wait();
            end
            random_message();
            random_sent = requests_sent - directed_sent;
        end

        drain_wait();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (ledger.owed_q.size() != 0) begin
            ledger.faults++;
            $display("%0d owed results never arrived", ledger.owed_q.size());
        end

        $display("covered %0d requests (%0d random), %0d results: %0d messages done, %0d payload bytes",
                 requests_sent, requests_sent - directed_sent, ledger.results_seen,
                 ledger.messages_done, ledger.payload_bytes);
        $display("errors: no length %0d, blank value %0d, bad value %0d, early end %0d",
                 ledger.error_tally[ERR_NO_LENGTH], ledger.error_tally[ERR_BLANK],
                 ledger.error_tally[ERR_BAD_VALUE], ledger.error_tally[ERR_EARLY_END]);
        if (ledger.faults == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
